// File: src/gtlj_pkg.sv
// ----------------------------------------------------------------------------
// gtlj_pkg
// Shared types and character constants for the greedy text line justifier.
// ----------------------------------------------------------------------------
package gtlj_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_W  = 6;
   localparam int WCNT_W = 5;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [CSR_W-1:0]  csr_type;
   typedef logic [WCNT_W-1:0] wcnt_type;

   localparam byte_type CHAR_TAB     = 8'd9;
   localparam byte_type CHAR_NEWLINE = 8'd10;
   localparam byte_type CHAR_SPACE   = 8'd32;
   localparam byte_type CHAR_STAR    = 8'd42;

   localparam csr_type WIDTH_RESET = 6'd32;

endpackage

// File: src/greedy_text_line_justifier_core.sv
// ----------------------------------------------------------------------------
// greedy_text_line_justifier_core
// Greedy word wrap with full justification over a byte stream.
// ----------------------------------------------------------------------------
// One text byte enters per item; tlast on the input marks end of text. A word
// byte is written to the word RAM in the cycle it is accepted, so plain text
// runs at one item per cycle. A separator closing a word passes through a
// decide state and, for the joining space, a space state; the word is then
// copied byte by byte into the line RAM. A line that overflows is sent out
// first through the line RAM's read port at one output byte per cycle while
// the result channel accepts, with a pause at each gap; end of text sends
// the rest of the line unjustified after a setup state. Results leave through
// a one-deep output register; a stalled result channel stalls the sequencer.
// ----------------------------------------------------------------------------
module greedy_text_line_justifier_core
   import gtlj_pkg::*;
#(
   parameter int LINE_MAX = 32,
   parameter int WORD_MAX = 20
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] text_byte
   input  logic         req_tlast,   // end_of_text
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [7:0]   rsp_tdata,   // [7:0] out_byte
   output logic         rsp_tlast,   // last
   input  logic         csr_wr_en,
   input  logic [5:0]   csr_wr_data  // [5:0] line_width
);

   localparam int LL_W = $clog2(LINE_MAX + 1);
   localparam int LA_W = $clog2(LINE_MAX);
   localparam int WL_W = $clog2(WORD_MAX + 2);
   localparam int WA_W = $clog2(WORD_MAX + 1);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_DECIDE  = 3'd1;
   localparam logic [2:0] S_SPACE   = 3'd2;
   localparam logic [2:0] S_COPY    = 3'd3;
   localparam logic [2:0] S_JUST    = 3'd4;
   localparam logic [2:0] S_GAP     = 3'd5;
   localparam logic [2:0] S_RAWPREP = 3'd6;
   localparam logic [2:0] S_RAW     = 3'd7;

   logic [2:0]      state_ff, state_in;
   csr_type         width_ff;
   logic [LL_W-1:0] line_used_ff, line_used_in;
   wcnt_type        word_cnt_ff, word_cnt_in;
   logic [WL_W-1:0] word_used_ff, word_used_in;
   logic [LL_W-1:0] idx_ff, idx_in;
   logic [WL_W-1:0] wdx_ff, wdx_in;
   logic            eot_ff, eot_in;
   logic [LL_W-1:0] extra_ff, extra_in;
   logic [LL_W-1:0] acc_ff, acc_in;
   wcnt_type        words_ff, words_in;

   logic            rsp_valid_ff, rsp_valid_in;
   byte_type        rsp_data_ff, rsp_data_in;
   logic            rsp_last_ff, rsp_last_in;

   logic            req_acc, is_sep, out_free;
   logic [LL_W-1:0] eff_w, room;
   logic            overflow;
   wcnt_type        gaps;
   logic            emit, emit_last;
   byte_type        emit_byte;

   logic            line_we, word_we;
   byte_type        line_wdata, line_rd, word_rd;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign is_sep     = req_tdata inside {CHAR_SPACE, CHAR_TAB, CHAR_NEWLINE};
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (width_ff < CSR_W'(WORD_MAX + 2)) begin
         eff_w = LL_W'(WORD_MAX + 2);
      end else if (width_ff > CSR_W'(LINE_MAX)) begin
         eff_w = LL_W'(LINE_MAX);
      end else begin
         eff_w = LL_W'(width_ff);
      end
   end

   assign room     = (eff_w > line_used_ff) ? (eff_w - line_used_ff) : '0;
   assign overflow = (7'(word_used_ff) + 7'd1) > 7'(room);
   assign gaps     = (words_ff > WCNT_W'(1)) ? (words_ff - WCNT_W'(1)) : WCNT_W'(1);

   always_comb begin
      state_in     = state_ff;
      line_used_in = line_used_ff;
      word_cnt_in  = word_cnt_ff;
      word_used_in = word_used_ff;
      idx_in       = idx_ff;
      wdx_in       = wdx_ff;
      eot_in       = eot_ff;
      extra_in     = extra_ff;
      acc_in       = acc_ff;
      words_in     = words_ff;
      emit         = 1'b0;
      emit_byte    = CHAR_NEWLINE;
      emit_last    = 1'b0;
      line_we      = 1'b0;
      line_wdata   = CHAR_SPACE;
      word_we      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_tlast) begin
                  eot_in = 1'b1;
                  if (word_used_ff != '0) begin
                     state_in = S_DECIDE;
                  end else if (line_used_ff != '0) begin
                     idx_in   = '0;
                     state_in = S_RAWPREP;
                  end else begin
                     line_used_in = '0;
                     word_cnt_in  = '0;
                  end
               end else if (is_sep) begin
                  eot_in = 1'b0;
                  if (word_used_ff != '0) begin
                     state_in = S_DECIDE;
                  end
               end else if (word_used_ff < WL_W'(WORD_MAX + 1)) begin
                  word_we      = 1'b1;
                  word_used_in = word_used_ff + WL_W'(1);
               end
            end
         end
         S_DECIDE: begin
            idx_in   = '0;
            wdx_in   = '0;
            extra_in = room;
            words_in = word_cnt_ff;
            if (overflow) begin
               extra_in = (eff_w > line_used_ff) ? (eff_w - line_used_ff) : '0;
               state_in = S_JUST;
            end else if (word_cnt_ff != '0) begin
               state_in = S_SPACE;
            end else begin
               state_in = S_COPY;
            end
         end
         S_SPACE: begin
            line_we      = 1'b1;
            line_wdata   = CHAR_SPACE;
            line_used_in = line_used_ff + LL_W'(1);
            state_in     = S_COPY;
         end
         S_COPY: begin
            line_we = 1'b1;
            if (wdx_ff == WL_W'(WORD_MAX) && word_used_ff > WL_W'(WORD_MAX)) begin
               line_wdata = CHAR_STAR;
            end else begin
               line_wdata = word_rd;
            end
            line_used_in = line_used_ff + LL_W'(1);
            wdx_in       = wdx_ff + WL_W'(1);
            if (wdx_ff + WL_W'(1) == word_used_ff) begin
               word_cnt_in  = word_cnt_ff + WCNT_W'(1);
               word_used_in = '0;
               wdx_in       = '0;
               if (eot_ff) begin
                  idx_in   = '0;
                  state_in = S_RAWPREP;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_JUST: begin
            if (out_free) begin
               if (idx_ff == line_used_ff) begin
                  emit         = 1'b1;
                  emit_byte    = CHAR_NEWLINE;
                  emit_last    = !eot_ff;
                  line_used_in = '0;
                  word_cnt_in  = '0;
                  state_in     = S_COPY;
               end else if (line_rd != CHAR_SPACE) begin
                  emit      = 1'b1;
                  emit_byte = line_rd;
                  idx_in    = idx_ff + LL_W'(1);
               end else begin
                  acc_in   = extra_ff;
                  state_in = S_GAP;
               end
            end
         end
         S_GAP: begin
            if (out_free) begin
               emit      = 1'b1;
               emit_byte = CHAR_SPACE;
               if (7'(acc_ff) >= 7'(gaps)) begin
                  acc_in   = acc_ff - LL_W'(gaps);
                  extra_in = extra_ff - LL_W'(1);
               end else begin
                  if (words_ff != '0) begin
                     words_in = words_ff - WCNT_W'(1);
                  end
                  idx_in   = idx_ff + LL_W'(1);
                  state_in = S_JUST;
               end
            end
         end
         S_RAWPREP: begin
            state_in = S_RAW;
         end
         S_RAW: begin
            if (out_free) begin
               emit = 1'b1;
               if (idx_ff == line_used_ff) begin
                  emit_byte    = CHAR_NEWLINE;
                  emit_last    = 1'b1;
                  line_used_in = '0;
                  word_cnt_in  = '0;
                  word_used_in = '0;
                  state_in     = S_IDLE;
               end else begin
                  emit_byte = line_rd;
                  idx_in    = idx_ff + LL_W'(1);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit_byte;
         rsp_last_in  = emit_last;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= WIDTH_RESET;
         line_used_ff <= '0;
         word_cnt_ff  <= '0;
         word_used_ff <= '0;
         idx_ff       <= '0;
         wdx_ff       <= '0;
         eot_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         line_used_ff <= line_used_in;
         word_cnt_ff  <= word_cnt_in;
         word_used_ff <= word_used_in;
         idx_ff       <= idx_in;
         wdx_ff       <= wdx_in;
         eot_ff       <= eot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      extra_ff    <= extra_in;
      acc_ff      <= acc_in;
      words_ff    <= words_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   gtlj_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LINE_MAX)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (line_used_ff[LA_W-1:0]),
      .wr_data (line_wdata),
      .rd_addr (idx_in[LA_W-1:0]),
      .rd_data (line_rd)
   );

   gtlj_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (WORD_MAX + 1)
   ) u_word_ram (
      .clock   (clock),
      .wr_en   (word_we),
      .wr_addr (word_used_ff[WA_W-1:0]),
      .wr_data (req_tdata),
      .rd_addr (wdx_in[WA_W-1:0]),
      .rd_data (word_rd)
   );

`ifndef NO_ASSERTIONS
   a_line_len_bound: assert property (@(posedge clock) disable iff (reset)
      7'(line_used_ff) <= 7'(LINE_MAX))
      else $error("line length beyond line store");

   a_copy_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY) |->
      (7'(line_used_ff) + 7'(word_used_ff) - 7'(wdx_ff) <= 7'(LINE_MAX)))
      else $error("word copy overruns line store");

   a_copy_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_COPY) |-> (wdx_ff < word_used_ff))
      else $error("word copy index past word length");

   a_gap_words: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_GAP) |-> (words_ff >= WCNT_W'(2)))
      else $error("gap reached with fewer than two words left");

   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |=> $stable(rsp_data_ff) && $stable(rsp_last_ff))
      else $error("pending item overwritten while stalled");
`endif

endmodule

// File: src/gtlj_ram.sv
// ----------------------------------------------------------------------------
// gtlj_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gtlj_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for greedy_text_line_justifier_core.
// ----------------------------------------------------------------------------
// Text bytes go in as streams of random words, separators and end-of-text
// marks. A bit-true line filler inside the bench predicts every output byte.
// Each received byte is checked in order against that prediction. The line
// width is changed between phases, including to values outside the legal
// range. Both sides insert random idle gaps. The receiver also holds off once
// for a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb
   import gtlj_pkg::*;
();

   localparam int LINE_CAP     = 32;
   localparam int WORD_CAP     = 20;
   localparam int SETTLE       = 64;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 5_000_000;
   localparam int PHASE_ITEMS  = 39;
   localparam int PHASE_COUNT  = 8;

   typedef struct {
      byte_type ch;
      logic     last;
   } text_out_type;

   typedef struct {
      byte_type ch;
      logic     eot;
   } text_in_type;

   class justified_text_board;
      csr_type      width_reg;
      byte_type     line_buf[LINE_CAP];
      byte_type     word_buf[WORD_CAP+1];
      int unsigned  line_used;
      int unsigned  words_on_line;
      int unsigned  word_used;
      text_out_type due_bytes[$];
      int unsigned  mismatches;
      int unsigned  checked;
      int unsigned  taken;

      function new();
         width_reg     = WIDTH_RESET;
         line_used     = 0;
         words_on_line = 0;
         word_used     = 0;
         mismatches    = 0;
         checked       = 0;
         taken         = 0;
      endfunction

      task report(input string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function void set_width(input csr_type w);
         width_reg = w;
      endfunction

      function int unsigned fit_width();
         int unsigned w;
         w = width_reg;
         if (w < WORD_CAP + 2) w = WORD_CAP + 2;
         if (w > LINE_CAP) w = LINE_CAP;
         return w;
      endfunction

      function void push_char(input byte_type c);
         text_out_type t;
         t.ch   = c;
         t.last = 1'b0;
         due_bytes.push_back(t);
      endfunction

      function void flush_justified();
         int unsigned w;
         int unsigned extra;
         int unsigned words;
         int unsigned gaps;
         int unsigned q;
         w     = fit_width();
         extra = (w > line_used) ? w - line_used : 0;
         words = words_on_line;
         for (int i = 0; i < line_used; i++) begin
            if (line_buf[i] != CHAR_SPACE) begin
               push_char(line_buf[i]);
            end else begin
               gaps = (words > 1) ? words - 1 : 1;
               q    = extra / gaps;
               for (int k = 0; k < q + 1; k++) push_char(CHAR_SPACE);
               extra = extra - q;
               if (words > 0) words--;
            end
         end
         push_char(CHAR_NEWLINE);
      endfunction

      function void close_word();
         int unsigned w;
         int unsigned room;
         if (word_used == 0) return;
         if (word_used > WORD_CAP) word_buf[WORD_CAP] = CHAR_STAR;
         w    = fit_width();
         room = (w > line_used) ? w - line_used : 0;
         if (word_used + 1 > room) begin
            flush_justified();
            line_used     = 0;
            words_on_line = 0;
         end
         if (words_on_line > 0 && line_used < LINE_CAP) begin
            line_buf[line_used] = CHAR_SPACE;
            line_used++;
         end
         for (int i = 0; i < word_used && i <= WORD_CAP; i++) begin
            if (line_used < LINE_CAP) begin
               line_buf[line_used] = word_buf[i];
               line_used++;
            end
         end
         words_on_line = (words_on_line + 1) & 5'h1F;
         word_used     = 0;
      endfunction

      function void take_text_item(input byte_type c, input logic eot);
         int unsigned first;
         first = due_bytes.size();
         taken++;
         if (eot) begin
            close_word();
            if (line_used > 0) begin
               for (int i = 0; i < line_used; i++) push_char(line_buf[i]);
               push_char(CHAR_NEWLINE);
            end
            line_used     = 0;
            words_on_line = 0;
            word_used     = 0;
         end else if (c == CHAR_TAB || c == CHAR_NEWLINE || c == CHAR_SPACE) begin
            close_word();
         end else if (word_used < WORD_CAP + 1) begin
            word_buf[word_used] = c;
            word_used++;
         end
         if (due_bytes.size() > first) due_bytes[due_bytes.size()-1].last = 1'b1;
      endfunction

      task match_out_byte(input byte_type c, input logic last);
         text_out_type t;
         checked++;
         if (due_bytes.size() == 0) begin
            report($sformatf("unexpected byte %0d last %0d", c, last));
         end else begin
            t = due_bytes.pop_front();
            if (c !== t.ch)
               report($sformatf("out_byte %0d, predicted %0d", c, t.ch));
            if (last !== t.last)
               report($sformatf("last %0d, predicted %0d", last, t.last));
         end
      endtask
   endclass

   logic       clock;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic       rsp_tlast;
   logic       csr_wr_en;
   logic [5:0] csr_wr_data;

   justified_text_board board;
   text_in_type         text_q[$];
   logic                no_idle;
   int unsigned         cycle_count;
   int unsigned         widths_used;

   greedy_text_line_justifier_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),   // [7:0] text_byte
      .req_tlast   (req_tlast),   // end_of_text
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),   // [7:0] out_byte
      .rsp_tlast   (rsp_tlast),   // last
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)  // [5:0] line_width
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.match_out_byte(rsp_tdata, rsp_tlast);
   end

   initial begin : watchdog
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      if (no_idle) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic byte_type pick_letter();
      byte_type c;
      do c = byte_type'($urandom_range(0, 255));
      while (c == CHAR_TAB || c == CHAR_NEWLINE || c == CHAR_SPACE);
      return c;
   endfunction

   function automatic byte_type pick_separator();
      case ($urandom_range(0, 2))
         0: return CHAR_TAB;
         1: return CHAR_NEWLINE;
         default: return CHAR_SPACE;
      endcase
   endfunction

   function automatic void queue_char(input byte_type c, input logic eot);
      text_in_type t;
      t.ch  = c;
      t.eot = eot;
      text_q.push_back(t);
   endfunction

   function automatic void queue_word(input int len);
      for (int i = 0; i < len; i++) queue_char(pick_letter(), 1'b0);
   endfunction

   task automatic send_item(input byte_type c, input logic eot);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_text_item(c, eot);
      @(negedge clock);
   endtask

   task automatic drain_queue();
      text_in_type t;
      while (text_q.size() != 0) begin
         t = text_q.pop_front();
         send_item(t.ch, t.eot);
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic write_width(input csr_type w);
      while (board.due_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= w;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      board.set_width(w);
      widths_used++;
   endtask

   task automatic build_text(input bit force_long, input bit close_text);
      int r;
      int len;
      while (text_q.size() < PHASE_ITEMS) begin
         r = $urandom_range(0, 99);
         if (force_long) begin
            len        = $urandom_range(22, 25);
            force_long = 1'b0;
         end else if (r < 75) begin
            len = $urandom_range(1, 7);
         end else if (r < 90) begin
            len = $urandom_range(8, 14);
         end else begin
            len = $urandom_range(15, 26);
         end
         queue_word(len);
         if ($urandom_range(0, 99) < 6) begin
            queue_char(pick_letter(), 1'b1);
         end else begin
            queue_char(pick_separator(), 1'b0);
            if ($urandom_range(0, 99) < 15) queue_char(pick_separator(), 1'b0);
         end
      end
      if (close_text) queue_char(byte_type'($urandom_range(0, 255)), 1'b1);
   endtask

   initial begin : receiver
      int  stall;
      bit  held_off;
      stall      = 0;
      held_off   = 1'b0;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (!held_off && board.checked >= 60) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         if (stall == 0 && !no_idle && $urandom_range(0, 3) == 0) stall = pick_gap();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            stall--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      csr_type widths[PHASE_COUNT];
      board       = new();
      cycle_count = 0;
      widths_used = 0;
      no_idle     = 1'b0;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      widths      = '{6'd0, 6'd63, 6'd22, 6'd21, 6'd33, 6'd40, 6'd0, 6'd0};
      widths[6]   = csr_type'($urandom_range(0, 63));
      widths[7]   = csr_type'($urandom_range(0, 63));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty text, extreme bytes, each separator, blank separator, end of text
      write_width(WIDTH_RESET);
      queue_char(8'h00, 1'b1);
      queue_char(8'h00, 1'b0);
      queue_char(8'hFF, 1'b0);
      queue_char(8'h41, 1'b0);
      queue_char(CHAR_TAB, 1'b0);
      queue_char(8'h62, 1'b0);
      queue_char(CHAR_NEWLINE, 1'b0);
      queue_char(CHAR_SPACE, 1'b0);
      queue_char(8'h7F, 1'b1);
      drain_queue();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         write_width(widths[p]);
         no_idle = (p == 3 || p == 6);
         build_text(p == 0, p == PHASE_COUNT - 1);
         drain_queue();
      end
      no_idle = 1'b0;

      while (board.due_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Fed %0d text items across %0d line width settings.",
               board.taken, widths_used);
      $display("Checked %0d output bytes, %0d mismatches.", board.checked,
               board.mismatches);
      if (board.mismatches == 0 && board.due_bytes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
